### hw/rtl/shs_pkg.sv
// Shared types, constants and round functions of the streaming SHA-256 hash block.
`default_nettype none

package shs_pkg;

    // Default depth of the word queue between the front end and the compression core.
    localparam int QUEUE_DEPTH_DEF = 4;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } shs_msg_t;

    // One output beat.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } shs_digest_t;

    // One message word on its way from the front end to the core.
    typedef struct packed {
        logic [31:0] word;
        logic        msg_end;
    } shs_word_t;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [3:0] LEN_HI_WORD  = 4'd14;
    localparam logic [2:0] LAST_WORD_IX = 3'd7;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/shs_front.sv
// Front end: takes message beats, packs bytes into words and appends the padding.
`default_nettype none

module shs_front
    import shs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      msg_valid,
    output logic      msg_ready,
    input  shs_msg_t  msg,
    output logic      push,
    output shs_word_t push_word,
    input  logic      full
);

    localparam logic [2:0] F_DATA  = 3'd0;
    localparam logic [2:0] F_PAD80 = 3'd1;
    localparam logic [2:0] F_PADZ  = 3'd2;
    localparam logic [2:0] F_LENHI = 3'd3;
    localparam logic [2:0] F_LENLO = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    // Byte count, 61 bits wide; shifted left by three it forms the 64-bit bit length.
    logic [60:0] count_reg, count_next;
    logic [23:0] acc_reg, acc_next;
    logic [3:0]  word_inc;

    assign word_inc = fill_reg[5:2] + 4'd1;

    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        count_next        = count_reg;
        acc_next          = acc_reg;
        push              = 1'b0;
        push_word.word    = '0;
        push_word.msg_end = 1'b0;
        msg_ready         = (state_reg == F_DATA) && !full;
        unique case (state_reg)
            F_DATA:
            begin
                if (msg_valid && msg_ready)
                begin
                    if (msg.has_byte)
                    begin
                        count_next = count_reg + 61'd1;
                        fill_next  = fill_reg + 6'd1;
                        acc_next   = {acc_reg[15:0], msg.data_byte};
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            push           = 1'b1;
                            push_word.word = {acc_reg, msg.data_byte};
                        end
                    end
                    if (msg.last)
                        state_next = F_PAD80;
                end
            end
            F_PAD80:
            begin
                if (!full)
                begin
                    push = 1'b1;
                    case (fill_reg[1:0])
                        2'd0:    push_word.word = {PAD_MARK, 24'h0};
                        2'd1:    push_word.word = {acc_reg[7:0], PAD_MARK, 16'h0};
                        2'd2:    push_word.word = {acc_reg[15:0], PAD_MARK, 8'h0};
                        default: push_word.word = {acc_reg, PAD_MARK};
                    endcase
                    fill_next  = {word_inc, 2'b00};
                    state_next = (word_inc == LEN_HI_WORD) ? F_LENHI : F_PADZ;
                end
            end
            F_PADZ:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    fill_next  = {word_inc, 2'b00};
                    if (word_inc == LEN_HI_WORD)
                        state_next = F_LENHI;
                end
            end
            F_LENHI:
            begin
                if (!full)
                begin
                    push           = 1'b1;
                    push_word.word = count_reg[60:29];
                    fill_next      = {word_inc, 2'b00};
                    state_next     = F_LENLO;
                end
            end
            F_LENLO:
            begin
                if (!full)
                begin
                    push              = 1'b1;
                    push_word.word    = {count_reg[28:0], 3'b000};
                    push_word.msg_end = 1'b1;
                    fill_next         = '0;
                    count_next        = '0;
                    state_next        = F_DATA;
                end
            end
            default:
            begin
                state_next = F_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_DATA;
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

### hw/rtl/shs_queue.sv
// Short word queue that lets the front end and the compression core stall on their own.
`default_nettype none

module shs_queue
    import shs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  shs_word_t push_word,
    output logic      full,
    input  logic      pop,
    output shs_word_t q_word,
    output logic      q_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    shs_word_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_word  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

endmodule

`default_nettype wire

### hw/rtl/shs_core.sv
// Compression core: one SHA-256 round per cycle while fed; chaining value; digest read-out.
`default_nettype none

module shs_core
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  shs_word_t   q_word,
    output logic        pop,
    output logic        digest_valid,
    input  logic        digest_ready,
    output shs_digest_t digest
);

    localparam logic [1:0] B_LOAD  = 2'd0;
    localparam logic [1:0] B_SCHED = 2'd1;
    localparam logic [1:0] B_ADD   = 2'd2;
    localparam logic [1:0] B_OUT   = 2'd3;

    localparam logic [5:0] LAST_LOAD_ROUND = 6'd15;
    localparam logic [5:0] LAST_ROUND      = 6'd63;

    logic [1:0]  state_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic        end_reg;
    logic [31:0] chain_reg  [8];
    logic [31:0] v_reg      [8];
    logic [31:0] window_reg [16];

    logic [31:0] w_sched, w_cur, choose, major, t1, t2;
    logic        do_round;

    // The window holds the last sixteen schedule words, oldest at index 0.
    assign w_sched  = small_sig1(window_reg[14]) + window_reg[9]
                    + small_sig0(window_reg[1]) + window_reg[0];
    assign w_cur    = (state_reg == B_LOAD) ? q_word.word : w_sched;
    assign choose   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign major    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1       = v_reg[7] + big_sig1(v_reg[4]) + choose + ROUND_K[round_reg] + w_cur;
    assign t2       = big_sig0(v_reg[0]) + major;
    assign pop      = (state_reg == B_LOAD) && q_valid;
    assign do_round = pop || (state_reg == B_SCHED);

    assign digest_valid       = (state_reg == B_OUT);
    assign digest.digest_word = chain_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == LAST_WORD_IX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_LOAD;
            round_reg <= '0;
            idx_reg   <= '0;
            end_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
                v_reg[i]     <= INIT_HASH[i];
            end
        end
        else
        begin
            if (do_round)
            begin
                v_reg[7]  <= v_reg[6];
                v_reg[6]  <= v_reg[5];
                v_reg[5]  <= v_reg[4];
                v_reg[4]  <= v_reg[3] + t1;
                v_reg[3]  <= v_reg[2];
                v_reg[2]  <= v_reg[1];
                v_reg[1]  <= v_reg[0];
                v_reg[0]  <= t1 + t2;
                round_reg <= round_reg + 6'd1;
            end
            unique case (state_reg)
                B_LOAD:
                begin
                    if (q_valid)
                    begin
                        end_reg <= q_word.msg_end;
                        if (round_reg == LAST_LOAD_ROUND)
                            state_reg <= B_SCHED;
                    end
                end
                B_SCHED:
                begin
                    if (round_reg == LAST_ROUND)
                        state_reg <= B_ADD;
                end
                B_ADD:
                begin
                    // Working variables start the next block equal to the new chaining value.
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                        v_reg[i]     <= chain_reg[i] + v_reg[i];
                    end
                    idx_reg   <= '0;
                    state_reg <= end_reg ? B_OUT : B_LOAD;
                end
                B_OUT:
                begin
                    if (digest_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == LAST_WORD_IX)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= INIT_HASH[i];
                                v_reg[i]     <= INIT_HASH[i];
                            end
                            state_reg <= B_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_round)
        begin
            for (int i = 0; i < 15; i++)
                window_reg[i] <= window_reg[i + 1];
            window_reg[15] <= w_cur;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sha256_stream_hash_top.sv
// Top level of the streaming SHA-256 hash block.
//
//   Channel   Handshake                   Payload        Beat carries
//   msg       msg_valid / msg_ready       shs_msg_t      one message byte, byte flag, end flag
//   digest    digest_valid / digest_ready shs_digest_t   one 32-bit digest word and its index
//
// A message beat is taken while the front end is in its data state and the word queue has
// room. A beat that ends the message is followed by the padding and length words, which the
// front end writes one word per cycle while the queue has room. The core works through each
// 64-byte block in order (16 rounds fed from the queue, 48 rounds from the schedule window,
// then the chaining add), so it sets the long-run rate; it then presents the eight digest
// words, one per beat. A stalled digest channel stops the core only; the front end keeps
// taking bytes of the next message until the queue fills. Reset returns the chaining value
// to the initial hash and empties the queue; there is no clearing pass.
`default_nettype none

module sha256_stream_hash_top
    import shs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  shs_msg_t    msg,
    output logic        digest_valid,
    input  logic        digest_ready,
    output shs_digest_t digest
);

    logic      push, full, pop, q_valid;
    shs_word_t push_word, q_word;

    // Front end: byte packing, bit-length count and padding.
    shs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .push      (push),
        .push_word (push_word),
        .full      (full)
    );

    // Word queue between the two halves; the last word of a message carries the end mark.
    shs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop       (pop),
        .q_word    (q_word),
        .q_valid   (q_valid)
    );

    // Back end: rounds, chaining value and digest read-out.
    shs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .pop          (pop),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

endmodule

`default_nettype wire

### hw/rtl/shs_checker.sv
// Port-level checks of the hash block, bound to the top level.
`default_nettype none

module shs_checker
    import shs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_ready,
    input shs_msg_t    msg,
    input logic        digest_valid,
    input logic        digest_ready,
    input shs_digest_t digest
);

    // A stalled digest beat stays up and unchanged.
    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest))
        else $error("digest beat dropped or changed while stalled");

    // Digest words follow one another in index order without a gap.
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !digest.last_word
        |=> digest_valid && (digest.word_index == $past(digest.word_index) + 3'd1))
        else $error("digest word index did not advance by one");

    // The final flag marks the eighth word and no other.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_index == LAST_WORD_IX)))
        else $error("last word flag does not match word index");

    // A digest always starts at its first word.
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> (digest.word_index == 3'd0))
        else $error("digest did not start at word zero");

    // After the end of a message the front end is busy padding.
    a_pad_busy: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg.last |=> !msg_ready)
        else $error("message beat taken during padding");

endmodule

bind sha256_stream_hash_top shs_checker u_checker (.*);

`default_nettype wire

### dv/tb_sha256_stream_hash_top.sv
// Self-checking testbench of the streaming SHA-256 hash block against a built-in hash predictor.
`timescale 1ns / 1ps

module tb_sha256_stream_hash_top;
    import shs_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          DRAIN_CYCLES   = 200;
    localparam logic [7:0]  PAD_BYTE       = 8'h80;
    localparam int unsigned LENGTH_OFFSET  = 56;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        msg_valid    = 1'b0;
    logic        msg_ready;
    shs_msg_t    msg          = '0;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    shs_digest_t digest;

    // Idle percentages of the two sides; the stimulus process changes them between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Predictor state: running chaining value, partial block and message length.
    logic [31:0] hash_chain [8];
    logic [7:0]  block_bytes [64];
    int unsigned block_fill;
    logic [63:0] msg_byte_count;

    shs_digest_t expected_digests [$];
    int          mismatches     = 0;
    int          quiet_cycles   = 0;
    int unsigned beats_sent     = 0;

    sha256_stream_hash_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            hash_chain[i] = SHA_IV[i];
        end
        block_fill     = 0;
        msg_byte_count = '0;
    endfunction

    // Folds the 64 buffered bytes into the chaining value.
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            w[i] = w[i-16] + w[i-7]
                 + (rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
        e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25))
                   + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
            t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
        hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        block_bytes[block_fill] = b;
        block_fill++;
        if (block_fill == 64)
        begin
            compress_block();
            block_fill = 0;
        end
    endfunction

    // Applies one accepted message beat and queues the eight digest words on an end beat.
    function automatic void predict_beat(input shs_msg_t beat);
        logic [63:0] bit_len;
        shs_digest_t word;
        if (beat.has_byte)
        begin
            msg_byte_count++;
            absorb_byte(beat.data_byte);
        end
        if (beat.last)
        begin
            bit_len = msg_byte_count << 3;
            absorb_byte(PAD_BYTE);
            while (block_fill != LENGTH_OFFSET)
            begin
                absorb_byte(8'h00);
            end
            for (int i = 7; i >= 0; i--)
            begin
                absorb_byte(bit_len[8*i +: 8]);
            end
            for (int i = 0; i < 8; i++)
            begin
                word.digest_word = hash_chain[i];
                word.word_index  = 3'(i);
                word.last_word   = (i == 7);
                expected_digests.push_back(word);
            end
            restart_hash();
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitors, checker, receiver and watchdog
    // ------------------------------------------------------------------

    // Every message beat taken by the block updates the predictor at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && msg_valid && msg_ready)
        begin
            predict_beat(msg);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: digest %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Each digest beat is compared with the oldest predicted word.
    always @(posedge clk)
    begin
        shs_digest_t want;
        if (rst_n && digest_valid && digest_ready)
        begin
            if (expected_digests.size() == 0)
            begin
                $display("%0t: unexpected digest beat: expected none, actual %h/%0d/%0b",
                         $time, digest.digest_word, digest.word_index, digest.last_word);
                mismatches++;
            end
            else
            begin
                want = expected_digests.pop_front();
                check_field("word", want.digest_word, digest.digest_word);
                check_field("index", 32'(want.word_index), 32'(digest.word_index));
                check_field("last flag", 32'(want.last_word), 32'(digest.last_word));
            end
        end
    end

    // The receiver drops ready at random, as often as the current phase asks.
    always @(negedge clk)
    begin
        digest_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Counts edges at which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (msg_valid && msg_ready) || (digest_valid && digest_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("%0t: watchdog expired with %0d digest words outstanding",
                 $time, expected_digests.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic shs_msg_t make_beat(input logic [7:0] data, input logic has_byte,
                                           input logic last);
        shs_msg_t beat;
        beat.data_byte = data;
        beat.has_byte  = has_byte;
        beat.last      = last;
        return beat;
    endfunction

    // Sends one beat; called at a falling edge and returns at the falling edge after acceptance.
    // Valid stays high from one beat to the next unless a gap is drawn.
    task automatic send_beat(input shs_msg_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg_valid <= 1'b0;
            @(negedge clk);
        end
        msg_valid <= 1'b1;
        msg       <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!msg_ready);
        beats_sent++;
        @(negedge clk);
    endtask

    // Sends one random message, with idle noise mixed in and the end either on the final
    // byte or on a separate end-only beat.
    task automatic send_message(input int unsigned len);
        bit end_on_byte;
        end_on_byte = (len != 0) && ($urandom_range(1) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_beat(make_beat(8'($urandom_range(255)), 1'b0, 1'b0));
            end
            send_beat(make_beat(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1)));
        end
        if (!end_on_byte)
        begin
            send_beat(make_beat(8'($urandom_range(255)), 1'b0, 1'b1));
        end
    endtask

    // Mostly short messages, with lengths around the padding and block limits mixed in.
    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            return $urandom_range(24);
        end
        if (sel < 90)
        begin
            case ($urandom_range(7))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                5: return 65;
                6: return 119;
                default: return 120;
            endcase
        end
        return $urandom_range(130, 25);
    endfunction

    // The end beat alone, with a data byte that must be ignored, hashes the empty string.
    task automatic test_empty_message();
        send_beat(make_beat(8'hff, 1'b0, 1'b1));
    endtask

    // Classic three-byte message with the end carried by the final byte.
    task automatic test_byte_with_end();
        send_beat(make_beat(8'h61, 1'b1, 1'b0));
        send_beat(make_beat(8'h62, 1'b1, 1'b0));
        send_beat(make_beat(8'h63, 1'b1, 1'b1));
    endtask

    // Idle beats inside a message change nothing; the message then ends on an end-only beat.
    task automatic test_idle_beats();
        send_beat(make_beat(8'h00, 1'b1, 1'b0));
        send_beat(make_beat(8'h5a, 1'b0, 1'b0));
        send_beat(make_beat(8'hff, 1'b1, 1'b0));
        send_beat(make_beat(8'ha5, 1'b0, 1'b0));
        send_beat(make_beat(8'h00, 1'b0, 1'b1));
    endtask

    // All-ones and all-zero bytes.
    task automatic test_extreme_bytes();
        for (int i = 0; i < 8; i++)
        begin
            send_beat(make_beat((i < 4) ? 8'hff : 8'h00, 1'b1, i == 7));
        end
    endtask

    task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned beat_goal);
        int unsigned stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = beats_sent + beat_goal;
        while (beats_sent < stop_at)
        begin
            send_message(pick_length());
        end
    endtask

    initial
    begin
        restart_hash();
        send_idle_pct = 24;
        recv_idle_pct = 85;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_message();
        test_byte_with_end();
        test_idle_beats();
        test_extreme_bytes();

        // Slow receiver, then slow sender, then both at full rate.
        test_random_stream(24, 85, 120);
        test_random_stream(85, 24, 120);
        test_random_stream(0, 0, 115);

        msg_valid <= 1'b0;
        while (expected_digests.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
